[design/epu_pkg.sv]
// Package for the encoder position unwrap block.
// Holds the opcode type and the fixed field widths; used by the top level and its checker.
`default_nettype none

package epu_pkg;

  localparam int FIELD_W = 23;   // width of the angle and raw position fields
  localparam int CNT_W   = 32;   // width of the total, speed and sequence fields
  localparam int PP_W    = 8;    // width of the pole pair register

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ALIGN  = 2'd1,
    OP_SPEED  = 2'd2
  } op_t;

endpackage

`default_nettype wire

[design/encoder_position_unwrap_angle.sv]
// An accepted item goes through the input register, then the result (state) registers.
// Throughput: one item per cycle while the output is not stalled; the state update is one 23x8 multiply plus adds.
// Result fields are the state registers themselves, so they hold while the output stalls.
// Reset (rst, synchronous) clears all state, sets pp_count to 1 and empties the pipeline.
// Depends on epu_pkg.
`default_nettype none

module encoder_position_unwrap_angle
  import epu_pkg::*;
#(
  parameter int POS_BITS = 23
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [PP_W-1:0]          cfg_data,
  // sample channel
  input  wire logic                     sample_valid,
  output logic                          sample_stall,
  input  wire logic [1:0]               opcode,
  input  wire logic [FIELD_W-1:0]       raw_position,
  // result channel
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic [FIELD_W-1:0]            angle_elec,
  output logic [FIELD_W-1:0]            angle_mech,
  output logic signed [CNT_W-1:0]       multi_turn_pos,
  output logic signed [CNT_W-1:0]       speed_delta,
  output logic [CNT_W-1:0]              update_seq
);

  localparam int P    = POS_BITS;
  localparam int RAWW = (P > FIELD_W) ? P : FIELD_W;
  localparam int DW   = P + 2;
  localparam logic signed [DW-1:0] HALF = DW'(1) <<< (P - 1);
  localparam logic signed [DW-1:0] FULL = DW'(1) <<< P;

  // handshake
  logic in_accept;
  logic out_free;
  logic advance;

  // input register
  logic         s1_valid;
  op_t          s1_op;
  logic [P-1:0] s1_raw;

  // state, which is also the result register
  logic [PP_W-1:0]  pp_count;
  logic [P-1:0]     last_raw;
  logic             raw_seen;
  logic [CNT_W-1:0] total_count;
  logic [CNT_W-1:0] total_at_speed;
  logic [P-1:0]     zero_offset;
  logic [P-1:0]     angle_e;
  logic [CNT_W-1:0] seq_count;
  logic [CNT_W-1:0] speed_reg;

  logic [CNT_W-1:0] total_count_next;
  logic [CNT_W-1:0] total_at_speed_next;
  logic [P-1:0]     last_raw_next;
  logic             raw_seen_next;
  logic [P-1:0]     zero_offset_next;
  logic [P-1:0]     angle_e_next;
  logic [CNT_W-1:0] seq_count_next;
  logic [CNT_W-1:0] speed_reg_next;

  // datapath
  logic [RAWW-1:0]      raw_ext;
  logic [P-1:0]         raw_in;
  logic [P-1:0]         mul_a;
  logic [P+PP_W-1:0]    prod;
  logic [P-1:0]         elec_raw;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] step;
  logic [CNT_W-1:0]     step_ext;
  logic [RAWW-1:0]      elec_out;
  logic [RAWW-1:0]      mech_out;

  assign cfg_ready = 1'b1;

  assign out_free     = !result_valid || !result_stall;
  assign advance      = s1_valid && out_free;
  assign sample_stall = s1_valid && !out_free;
  assign in_accept    = sample_valid && !sample_stall;

  assign raw_ext = RAWW'(raw_position);
  assign raw_in  = raw_ext[P-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op  <= op_t'(opcode);
      s1_raw <= raw_in;
    end
  end

  // One multiplier serves both the sample angle and the align offset.
  assign mul_a    = (s1_op == OP_SAMPLE) ? s1_raw : last_raw;
  assign prod     = (P + PP_W)'(mul_a) * (P + PP_W)'(pp_count);
  assign elec_raw = prod[P-1:0];

  // A step of exactly half a turn keeps its sign and is not folded.
  assign diff = $signed({2'b00, s1_raw}) - $signed({2'b00, last_raw});
  always_comb begin
    if (diff > HALF) begin
      step = diff - FULL;
    end else if (diff < -HALF) begin
      step = diff + FULL;
    end else begin
      step = diff;
    end
  end
  assign step_ext = CNT_W'(step);

  always_comb begin
    total_count_next    = total_count;
    total_at_speed_next = total_at_speed;
    last_raw_next       = last_raw;
    raw_seen_next       = raw_seen;
    zero_offset_next    = zero_offset;
    angle_e_next        = angle_e;
    seq_count_next      = seq_count;
    speed_reg_next      = speed_reg;
    case (s1_op)
      OP_SAMPLE: begin
        total_count_next = raw_seen ? (total_count + step_ext) : CNT_W'(s1_raw);
        raw_seen_next    = 1'b1;
        last_raw_next    = s1_raw;
        angle_e_next     = elec_raw - zero_offset;
        seq_count_next   = seq_count + CNT_W'(1);
      end
      OP_ALIGN: begin
        zero_offset_next = elec_raw;
      end
      OP_SPEED: begin
        speed_reg_next      = total_count - total_at_speed;
        total_at_speed_next = total_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_count       <= PP_W'(1);
      last_raw       <= '0;
      raw_seen       <= 1'b0;
      total_count    <= '0;
      total_at_speed <= '0;
      zero_offset    <= '0;
      angle_e        <= '0;
      seq_count      <= '0;
      speed_reg      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pp_count <= cfg_data;
      end
      if (advance) begin
        last_raw       <= last_raw_next;
        raw_seen       <= raw_seen_next;
        total_count    <= total_count_next;
        total_at_speed <= total_at_speed_next;
        zero_offset    <= zero_offset_next;
        angle_e        <= angle_e_next;
        seq_count      <= seq_count_next;
        speed_reg      <= speed_reg_next;
      end
    end
  end

  assign elec_out       = RAWW'(angle_e);
  assign mech_out       = RAWW'(last_raw);
  assign angle_elec     = elec_out[FIELD_W-1:0];
  assign angle_mech     = mech_out[FIELD_W-1:0];
  assign multi_turn_pos = $signed(total_count);
  assign speed_delta    = $signed(speed_reg);
  assign update_seq     = seq_count;

endmodule

`default_nettype wire

[design/epu_checker.sv]
// Port-level checker for encoder_position_unwrap_angle, attached by the bind below.
// Depends on epu_pkg for field widths.
`default_nettype none

module epu_checker
  import epu_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 sample_stall,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire logic [FIELD_W-1:0]   angle_elec,
  input wire logic [FIELD_W-1:0]   angle_mech,
  input wire logic signed [CNT_W-1:0] multi_turn_pos,
  input wire logic [CNT_W-1:0]     update_seq
);

  // A result that is held back keeps its fields.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(multi_turn_pos)
      && $stable(update_seq) && $stable(angle_elec))
    else $error("result changed while stalled");

  // The input side only stalls when a result is waiting and held back.
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without output back-pressure");

  // The sample count moves by one, and only with a new result.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && update_seq != $past(update_seq)
      |-> result_valid && update_seq == $past(update_seq) + CNT_W'(1))
    else $error("update_seq moved without a new result");

  // The mechanical angle never changes without a result to show it.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && angle_mech != $past(angle_mech) |-> result_valid)
    else $error("angle_mech changed without a result");

endmodule

bind encoder_position_unwrap_angle epu_checker u_epu_checker (.*);

`default_nettype wire
